// ----- rtl/vertex_bulge_deform_defines.svh -----
// Assertion macros shared by the vertex bulge deformer RTL.
// Needs nothing else; included by files that carry assertions.
`ifndef VERTEX_BULGE_DEFORM_DEFINES_SVH
`define VERTEX_BULGE_DEFORM_DEFINES_SVH

// same-cycle implication
`define VBD_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VBD_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/vbd_pkg.sv -----
// Package for the vertex bulge deformer: widths, register indexes, shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vbd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CW         = 32;          // coordinate width
  localparam int RW         = 31;          // radius / distance width
  localparam int SUM_W      = 2 * RW;      // sum of squares
  localparam int SQRT_STEPS = RW;
  localparam int PROD_W     = CW + RW;     // |m| * |d|
  localparam int DIV_STEPS  = CW;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;
  localparam int CNT_W      = 3;
  localparam logic [CNT_W-1:0] Q_FULL = Q_DEPTH[CNT_W-1:0];
  localparam int IDX_W      = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_STRENGTH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][CW-1:0] center;
    logic [RW-1:0]      radius;
    logic [CW-1:0]      strength;
  } vbd_cfg_t;

  // what the back end carries for every vertex
  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0]         dneg;
    logic [2:0][RW-1:0] dmag;
    logic               go;
  } vbd_ctx_t;

  typedef struct packed {
    vbd_ctx_t         ctx;
    logic [SUM_W-1:0] sum;
  } vbd_item_t;

endpackage
`default_nettype wire

// ----- rtl/vbd_front.sv -----
// Front end: accepts vertices, forms offsets to the centre, squares and classifies.
// Depends on vbd_pkg; pushes into vbd_queue.
`timescale 1ns / 1ps
`default_nettype none
module vbd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [vbd_pkg::CW-1:0]      in_x,
  input  logic [vbd_pkg::CW-1:0]      in_y,
  input  logic [vbd_pkg::CW-1:0]      in_z,
  input  vbd_pkg::vbd_cfg_t           cfg,
  input  logic [vbd_pkg::CNT_W-1:0]   q_count,
  output logic                        push_valid,
  output vbd_pkg::vbd_item_t          push_item
);

  logic                                accept;
  logic [2:0][vbd_pkg::CW-1:0]         pin;
  logic [2:0][vbd_pkg::CW:0]           dfull;
  logic [2:0][vbd_pkg::CW:0]           dabs;
  logic                                s1_v, s2_v;
  logic [2:0][vbd_pkg::CW-1:0]         s1_p, s2_p;
  logic [2:0]                          s1_neg, s2_neg;
  logic [2:0][vbd_pkg::CW:0]           s1_mag;
  logic [2:0][vbd_pkg::RW-1:0]         s2_mag;
  logic [2:0][vbd_pkg::SUM_W-1:0]      sq, s2_sq;
  logic [vbd_pkg::SUM_W-1:0]           rsq, s2_rsq;
  logic                                near, s2_near;
  logic [vbd_pkg::SUM_W+1:0]           sum3;
  logic [vbd_pkg::CNT_W-1:0]           occ;

  assign occ    = q_count + {{(vbd_pkg::CNT_W-1){1'b0}}, s1_v}
                          + {{(vbd_pkg::CNT_W-1){1'b0}}, s2_v};
  assign busy   = (occ >= vbd_pkg::Q_FULL);
  assign accept = start && !busy;
  assign pin    = {in_z, in_y, in_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dfull[i] = {pin[i][vbd_pkg::CW-1], pin[i]}
               - {cfg.center[i][vbd_pkg::CW-1], cfg.center[i]};
      dabs[i]  = dfull[i][vbd_pkg::CW] ? (~dfull[i] + 1'b1) : dfull[i];
    end
  end

  always_comb begin
    near = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (s1_mag[i] >= {2'b00, cfg.radius}) begin
        near = 1'b0;
      end
      sq[i] = {{vbd_pkg::RW{1'b0}}, s1_mag[i][vbd_pkg::RW-1:0]}
            * {{vbd_pkg::RW{1'b0}}, s1_mag[i][vbd_pkg::RW-1:0]};
    end
    rsq = {{vbd_pkg::RW{1'b0}}, cfg.radius} * {{vbd_pkg::RW{1'b0}}, cfg.radius};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= accept;
      s2_v <= s1_v;
    end
    s1_p   <= pin;
    for (int i = 0; i < 3; i++) begin
      s1_neg[i] <= dfull[i][vbd_pkg::CW];
      s1_mag[i] <= dabs[i];
      s2_mag[i] <= s1_mag[i][vbd_pkg::RW-1:0];
    end
    s2_p    <= s1_p;
    s2_neg  <= s1_neg;
    s2_sq   <= sq;
    s2_rsq  <= rsq;
    s2_near <= near;
  end

  // three-term add and the radius test
  assign sum3 = {2'b00, s2_sq[0]} + {2'b00, s2_sq[1]} + {2'b00, s2_sq[2]};

  always_comb begin
    push_valid        = s2_v;
    push_item.ctx.p    = s2_p;
    push_item.ctx.dneg = s2_neg;
    push_item.ctx.dmag = s2_mag;
    push_item.ctx.go   = s2_near && (sum3 < {2'b00, s2_rsq}) && (sum3 != '0);
    push_item.sum      = sum3[vbd_pkg::SUM_W-1:0];
  end

endmodule
`default_nettype wire

// ----- rtl/vbd_queue.sv -----
// Short request queue between front and back end.
// Depends on vbd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_bulge_deform_defines.svh"
module vbd_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_valid,
  input  vbd_pkg::vbd_item_t         push_item,
  output logic [vbd_pkg::CNT_W-1:0]  count,
  output logic                       pop,
  output vbd_pkg::vbd_item_t         head
);

  vbd_pkg::vbd_item_t         slots [vbd_pkg::Q_DEPTH];
  logic [vbd_pkg::Q_AW-1:0]   wptr, rptr;

  // back end never stalls: drain every cycle something is held
  assign pop  = (count != '0);
  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_valid) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push_valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push_valid) begin
        count <= count - 1'b1;
      end
    end
    if (push_valid) begin
      slots[wptr] <= push_item;
    end
  end

  `VBD_ASSERT_IMP(a_q_no_overflow, clk, rst, push_valid && !pop, count < vbd_pkg::Q_FULL, "queue overflow")
  `VBD_ASSERT_NXT(a_q_count_up, clk, rst, push_valid && !pop, count == $past(count) + 1'b1, "count up")
  `VBD_ASSERT_NXT(a_q_count_dn, clk, rst, pop && !push_valid, count == $past(count) - 1'b1, "count down")

endmodule
`default_nettype wire

// ----- rtl/vbd_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, payload carried along.
// Depends on vbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vbd_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  vbd_pkg::vbd_item_t       in_item,
  output logic                     out_valid,
  output vbd_pkg::vbd_ctx_t        out_ctx,
  output logic [vbd_pkg::RW-1:0]   out_dist
);

  localparam int N = vbd_pkg::SQRT_STEPS;
  localparam int W = vbd_pkg::SUM_W;

  logic [N:0]          v;
  vbd_pkg::vbd_ctx_t   ctx  [N+1];
  logic [W-1:0]        rem  [N+1];
  logic [W-1:0]        root [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    ctx[0]  <= in_item.ctx;
    rem[0]  <= in_item.sum;
    root[0] <= '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [W-1:0] BITK = W'(1) << (W - 2 - 2 * k);
    logic [W-1:0] trial;
    logic         take;
    assign trial = root[k] + BITK;
    assign take  = (rem[k] >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
      ctx[k+1]  <= ctx[k];
      rem[k+1]  <= take ? (rem[k] - trial) : rem[k];
      root[k+1] <= take ? ((root[k] >> 1) + BITK) : (root[k] >> 1);
    end
  end

  assign out_valid = v[N];
  assign out_ctx   = ctx[N];
  assign out_dist  = root[N][vbd_pkg::RW-1:0];

endmodule
`default_nettype wire

// ----- rtl/vbd_back.sv -----
// Back end: falloff divide, smoothstep, push multiply and divide, saturation.
// Depends on vbd_pkg; fed by vbd_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module vbd_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  vbd_pkg::vbd_ctx_t        in_ctx,
  input  logic [vbd_pkg::RW-1:0]   in_dist,
  input  vbd_pkg::vbd_cfg_t        cfg,
  output logic                     done,
  output logic [vbd_pkg::CW-1:0]   out_x,
  output logic [vbd_pkg::CW-1:0]   out_y,
  output logic [vbd_pkg::CW-1:0]   out_z,
  output logic                     moved
);

  localparam int F  = vbd_pkg::FRAC_BITS;
  localparam int CW = vbd_pkg::CW;
  localparam int RW = vbd_pkg::RW;
  localparam int DS = vbd_pkg::DIV_STEPS;
  localparam int PW = vbd_pkg::PROD_W;
  localparam logic [F+1:0] THREE = {2'b11, {F{1'b0}}};

  // ---- t = ((radius - dist) << F) / radius, F quotient bits
  logic [F:0]          tv;
  vbd_pkg::vbd_ctx_t   tctx  [F+1];
  logic [RW-1:0]       tdist [F+1];
  logic [RW:0]         trem  [F+1];
  logic [F-1:0]        tq    [F+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tv[0] <= 1'b0;
    end else begin
      tv[0] <= in_valid;
    end
    tctx[0]  <= in_ctx;
    tdist[0] <= in_dist;
    trem[0]  <= {1'b0, cfg.radius - in_dist};
    tq[0]    <= '0;
  end

  for (genvar k = 0; k < F; k++) begin : g_tdiv
    logic [RW:0] sh;
    logic        ge;
    assign sh = {trem[k][RW-1:0], 1'b0};
    assign ge = (sh >= {1'b0, cfg.radius});
    always_ff @(posedge clk) begin
      if (rst) begin
        tv[k+1] <= 1'b0;
      end else begin
        tv[k+1] <= tv[k];
      end
      tctx[k+1]  <= tctx[k];
      tdist[k+1] <= tdist[k];
      trem[k+1]  <= ge ? (sh - {1'b0, cfg.radius}) : sh;
      tq[k+1]    <= {tq[k][F-2:0], ge};
    end
  end

  // ---- smoothstep and strength scale
  logic                s1_v, s2_v, m_v, p_v;
  vbd_pkg::vbd_ctx_t   s1_ctx, s2_ctx, m_ctx, p_ctx;
  logic [RW-1:0]       s1_dist, s2_dist, m_dist, p_dist;
  logic [F-1:0]        s1_t, s1_t2;
  logic [F+1:0]        s2_s;
  logic [CW-1:0]       m_val;
  logic [2*F-1:0]      t2_full;
  logic [F+1:0]        factor;
  logic [2*F+1:0]      s_full;
  logic [CW+F+2:0]     m_full;
  logic [CW-1:0]       mabs;
  logic [2:0][PW-1:0]  pmag_n, p_mag;
  logic [2:0]          p_sg;

  assign t2_full = {{F{1'b0}}, tq[F]} * {{F{1'b0}}, tq[F]};
  assign factor  = THREE - {1'b0, s1_t, 1'b0};
  assign s_full  = {{(F+2){1'b0}}, s1_t2} * {{F{1'b0}}, factor};
  assign m_full  = $signed({{(F+3){cfg.strength[CW-1]}}, cfg.strength})
                 * $signed({{CW{1'b0}}, 1'b0, s2_s});
  assign mabs    = m_val[CW-1] ? (~m_val + 1'b1) : m_val;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pmag_n[j] = {{(PW-CW){1'b0}}, mabs} * {{(PW-RW){1'b0}}, m_ctx.dmag[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      m_v  <= 1'b0;
      p_v  <= 1'b0;
    end else begin
      s1_v <= tv[F];
      s2_v <= s1_v;
      m_v  <= s2_v;
      p_v  <= m_v;
    end
    s1_ctx  <= tctx[F];
    s1_dist <= tdist[F];
    s1_t    <= tq[F];
    s1_t2   <= t2_full[2*F-1:F];
    s2_ctx  <= s1_ctx;
    s2_dist <= s1_dist;
    s2_s    <= s_full[2*F+1:F];
    m_ctx   <= s2_ctx;
    m_dist  <= s2_dist;
    m_val   <= m_full[F+CW-1:F];  // floor shift of the signed product
    p_ctx   <= m_ctx;
    p_dist  <= m_dist;
    p_mag   <= pmag_n;
    for (int j = 0; j < 3; j++) begin
      p_sg[j] <= m_val[CW-1] ^ m_ctx.dneg[j];
    end
  end

  // ---- push = |m*d| / dist, three lanes, one quotient bit per stage
  logic [DS:0]          dv;
  vbd_pkg::vbd_ctx_t    dctx  [DS+1];
  logic [RW-1:0]        ddist [DS+1];
  logic [2:0]           dsg   [DS+1];
  logic [2:0][CW-1:0]   drem  [DS+1];
  logic [2:0][CW-1:0]   dlow  [DS+1];
  logic [2:0][CW-1:0]   dq    [DS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= p_v;
    end
    dctx[0]  <= p_ctx;
    ddist[0] <= p_dist;
    dsg[0]   <= p_sg;
    for (int j = 0; j < 3; j++) begin
      drem[0][j] <= {1'b0, p_mag[j][PW-1:CW]};
      dlow[0][j] <= p_mag[j][CW-1:0];
      dq[0][j]   <= '0;
    end
  end

  for (genvar k = 0; k < DS; k++) begin : g_pdiv
    logic [2:0][CW-1:0] sh;
    logic [2:0]         ge;
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        sh[j] = {drem[k][j][CW-2:0], dlow[k][j][CW-1]};
        ge[j] = (sh[j] >= {1'b0, ddist[k]});
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
      dctx[k+1]  <= dctx[k];
      ddist[k+1] <= ddist[k];
      dsg[k+1]   <= dsg[k];
      for (int j = 0; j < 3; j++) begin
        drem[k+1][j] <= ge[j] ? (sh[j] - {1'b0, ddist[k]}) : sh[j];
        dlow[k+1][j] <= {dlow[k][j][CW-2:0], 1'b0};
        dq[k+1][j]   <= {dq[k][j][CW-2:0], ge[j]};
      end
    end
  end

  // ---- add and saturate
  vbd_pkg::vbd_ctx_t   fctx;
  logic [2:0][CW-1:0]  res;
  logic [2:0][CW:0]    push;
  logic [2:0][CW+1:0]  wide;

  assign fctx = dctx[DS];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      push[j] = dsg[DS][j] ? (~{1'b0, dq[DS][j]} + 1'b1) : {1'b0, dq[DS][j]};
      wide[j] = {{2{fctx.p[j][CW-1]}}, fctx.p[j]} + {push[j][CW], push[j]};
      if (!fctx.go) begin
        res[j] = fctx.p[j];
      end else if (wide[j][CW+1:CW-1] == 3'b000 || wide[j][CW+1:CW-1] == 3'b111) begin
        res[j] = wide[j][CW-1:0];
      end else if (wide[j][CW+1]) begin
        res[j] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        res[j] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      moved <= 1'b0;
    end else begin
      done  <= dv[DS];
      moved <= dv[DS] && fctx.go;
    end
    out_x <= res[0];
    out_y <= res[1];
    out_z <= res[2];
  end

endmodule
`default_nettype wire

// ----- rtl/vertex_bulge_deform.sv -----
// Top level of the radial bulge deformer with smoothstep falloff.
// Depends on vbd_pkg, vbd_front, vbd_queue, vbd_sqrt and vbd_back.
//
// Usage:
//  - Input requests: drive in_x/in_y/in_z (signed Q16.16) with start; a request
//    is taken on a clock edge where start is high and busy is low.
//  - Results: done is high for exactly one cycle with out_x/out_y/out_z and moved.
//    One result per request, in request order. The receiver cannot stall.
//  - Configuration: cfg_valid/cfg_ready write channel, cfg_index selects
//    center_x, center_y, center_z, radius, strength (0..4); other indexes are
//    dropped. cfg_ready is always high. Write only while no request is in flight.
//  - Throughput: one vertex per cycle, sustained. busy only rises if the
//    queue between front and back end could fill, which the non-stalling
//    back end never lets happen.
//  - Stages: 2 front stages, 1 queue write, 32 root stages,
//    17 falloff-divide stages, 4 scale stages, 33 push-divide stages and
//    1 output register lie between the accepting edge and the edge that
//    takes the result. The bit-serial square root and the two long
//    divides make up most of them.
//  - Reset (rst, synchronous): registers return to center 0, radius 1.0,
//    strength 0; all in-flight requests are dropped.
`timescale 1ns / 1ps
`default_nettype none
module vertex_bulge_deform (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [vbd_pkg::CW-1:0]      in_x,
  input  logic [vbd_pkg::CW-1:0]      in_y,
  input  logic [vbd_pkg::CW-1:0]      in_z,
  output logic                        done,
  output logic [vbd_pkg::CW-1:0]      out_x,
  output logic [vbd_pkg::CW-1:0]      out_y,
  output logic [vbd_pkg::CW-1:0]      out_z,
  output logic                        moved,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [vbd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vbd_pkg::CW-1:0]      cfg_data
);

  vbd_pkg::vbd_cfg_t            cfg;
  logic                         q_push, q_pop, sq_valid;
  vbd_pkg::vbd_item_t           q_in, q_head;
  logic [vbd_pkg::CNT_W-1:0]    q_count;
  vbd_pkg::vbd_ctx_t            sq_ctx;
  logic [vbd_pkg::RW-1:0]       sq_dist;

  // register file; writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center   <= '0;
      cfg.radius   <= vbd_pkg::RW'(65536);
      cfg.strength <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (vbd_pkg::reg_idx_t'(cfg_index))
        vbd_pkg::REG_CENTER_X: cfg.center[0] <= cfg_data;
        vbd_pkg::REG_CENTER_Y: cfg.center[1] <= cfg_data;
        vbd_pkg::REG_CENTER_Z: cfg.center[2] <= cfg_data;
        vbd_pkg::REG_RADIUS:   cfg.radius    <= cfg_data[vbd_pkg::RW-1:0];
        vbd_pkg::REG_STRENGTH: cfg.strength  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: offsets, squares, inside test
  vbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .cfg        (cfg),
    .q_count    (q_count),
    .push_valid (q_push),
    .push_item  (q_in)
  );

  // decoupling queue
  vbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push),
    .push_item  (q_in),
    .count      (q_count),
    .pop        (q_pop),
    .head       (q_head)
  );

  // back, part one: distance
  vbd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_pop),
    .in_item   (q_head),
    .out_valid (sq_valid),
    .out_ctx   (sq_ctx),
    .out_dist  (sq_dist)
  );

  // back, part two: falloff and push
  vbd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .in_ctx   (sq_ctx),
    .in_dist  (sq_dist),
    .cfg      (cfg),
    .done     (done),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .moved    (moved)
  );

endmodule
`default_nettype wire
